>>> rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, status codes and the control and flag structs that pass
// between the top level and the row of compare-and-shift cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 16;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_DELETE = 1'b1
    } req_t;

    typedef struct packed {
        logic ins_en;
        logic del_en;
    } cell_cmd_t;

    typedef struct packed {
        logic ge;
        logic le;
    } cell_flags_t;

endpackage

>>> rtl/core/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one stored entry, compares it with the request value and takes the
// request value or the entry of its left or right neighbor when the row shifts.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic                                clk,
    input  spq_pkg::cell_cmd_t                  cmd,
    input  logic signed [spq_pkg::VALUE_W-1:0]  value,
    input  logic                                occ,
    input  spq_pkg::cell_flags_t                left_flags,
    input  logic signed [spq_pkg::VALUE_W-1:0]  left_entry,
    input  logic signed [spq_pkg::VALUE_W-1:0]  right_entry,
    output spq_pkg::cell_flags_t                flags,
    output logic                                hit,
    output logic signed [spq_pkg::VALUE_W-1:0]  entry,
    output logic signed [spq_pkg::VALUE_W-1:0]  entry_next
);

    logic signed [spq_pkg::VALUE_W-1:0] entry_reg;

    always_comb
    begin
        flags.ge = !occ || (value >= entry_reg);
        flags.le = occ && (entry_reg <= value);
        hit      = occ && (entry_reg == value) && !left_flags.le;
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en && flags.ge)
        begin
            entry_next = left_flags.ge ? left_entry : value;
        end
        else if (cmd.del_en && flags.le)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> rtl/core/sorted_priority_queue_core.sv
// An accepted word is held in req_reg and value_reg until it executes; its
// result word is registered at the end of the execute cycle, which waits while
// a stalled result is still held. No new word is taken until the held one has
// executed. The whole row compares and shifts at once, whatever the depth.
// Reset clears the entry count and the handshake state; entries need no reset.
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Keeps up to DEPTH signed values in descending order in a row of cells and
// answers each insert or delete word with status, head and entry count.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic signed [spq_pkg::VALUE_W-1:0]   value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [spq_pkg::STATUS_W-1:0]         status,
    output logic signed [spq_pkg::VALUE_W-1:0]   head_value,
    output logic                                 head_valid,
    output logic [CNT_W-1:0]                     entry_count
);

    logic                                busy_reg;
    logic                                busy_next;
    spq_pkg::req_t                       req_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    spq_pkg::status_t                    status_reg;
    spq_pkg::status_t                    status_next;
    logic signed [spq_pkg::VALUE_W-1:0]  head_value_reg;
    logic                                head_valid_reg;
    logic [CNT_W-1:0]                    entry_count_reg;

    logic                                in_accept;
    logic                                exec;
    logic                                full;
    logic                                empty;
    logic                                found;
    spq_pkg::cell_cmd_t                  cmd;

    spq_pkg::cell_flags_t                flags [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0]  entries [DEPTH];
    logic signed [spq_pkg::VALUE_W-1:0]  entries_next [DEPTH];
    logic [DEPTH-1:0]                    hits;

    assign in_accept = in_valid && !busy_reg;
    assign exec      = busy_reg && !(out_valid_reg && out_stall);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = |hits;

    always_comb
    begin
        cmd.ins_en = exec && (req_reg == spq_pkg::REQ_INSERT) && !full;
        cmd.del_en = exec && (req_reg == spq_pkg::REQ_DELETE) && found;
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        spq_pkg::cell_flags_t                left_flags;
        logic signed [spq_pkg::VALUE_W-1:0]  left_entry;
        logic signed [spq_pkg::VALUE_W-1:0]  right_entry;

        if (k == 0)
        begin : g_first
            assign left_flags = '0;
            assign left_entry = value_reg;
        end
        else
        begin : g_inner
            assign left_flags = flags[k-1];
            assign left_entry = entries[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_entry = entries[k];
        end
        else
        begin : g_body
            assign right_entry = entries[k+1];
        end

        spq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .value       (value_reg),
            .occ         (CNT_W'(k) < count_reg),
            .left_flags  (left_flags),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .flags       (flags[k]),
            .hit         (hits[k]),
            .entry       (entries[k]),
            .entry_next  (entries_next[k])
        );
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_OK;
        if (req_reg == spq_pkg::REQ_INSERT)
        begin
            if (full)
            begin
                status_next = spq_pkg::ST_OVERFLOW;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        else if (empty)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
        else if (!found)
        begin
            status_next = spq_pkg::ST_NOT_FOUND;
        end
        else
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (exec)
        begin
            busy_next = 1'b0;
        end
        else if (in_accept)
        begin
            busy_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg   <= spq_pkg::req_t'(req_type);
            value_reg <= value;
        end
        if (exec)
        begin
            status_reg      <= status_next;
            head_valid_reg  <= (count_next != '0);
            head_value_reg  <= (count_next != '0) ? entries_next[0] : '0;
            entry_count_reg <= count_next;
        end
    end

    assign in_stall    = busy_reg;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign head_value  = head_value_reg;
    assign head_valid  = head_valid_reg;
    assign entry_count = entry_count_reg;

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed request did not produce a result word");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins_en |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the entry count");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.del_en |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("delete did not shrink the entry count");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> head_valid_reg == (entry_count_reg != '0))
        else $error("head valid disagrees with entry count");

endmodule
